// ===== rtl/core/wspd_pkg.sv =====
// Shared types and constants for the WAV stream parser and downmixer.
package wspd_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] PCM_DEPTH = 16'd16;
    localparam logic [31:0] FMT_LEN   = 32'd16;

    localparam int FRAME_W = 31;
    localparam int DIV_W   = 5;
    localparam int CNT_W   = 5;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_INFO   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // One unit of work handed from the parser to the divide/output side.
    typedef struct packed {
        t_kind               kind;
        logic                neg;
        logic [FRAME_W-1:0]  dividend;
        logic [31:0]         rate;
        logic [15:0]         channels;
    } t_job;

endpackage

// ===== rtl/core/wspd_front.sv =====
// Byte-level RIFF/WAVE parser: tag checks, chunk walk, fmt capture, frame summing.
module wspd_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_file_start,
    output logic          o_job_valid,
    output wspd_pkg::t_job o_job
);
    import wspd_pkg::*;

    localparam int CI_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W = 17 + $clog2(MAX_CHANNELS);

    typedef enum logic [8:0] {
        PH_RIFF     = 9'b000000001,
        PH_RIFFSIZE = 9'b000000010,
        PH_WAVE     = 9'b000000100,
        PH_HDR      = 9'b000001000,
        PH_FMT      = 9'b000010000,
        PH_SKIP     = 9'b000100000,
        PH_PAD      = 9'b001000000,
        PH_DATA     = 9'b010000000,
        PH_IDLE     = 9'b100000000
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic [31:0]              r_bc, n_bc;
    logic [31:0]              r_tag, n_tag;
    logic [31:0]              r_size, n_size;
    logic [15:0]              r_chan, n_chan;
    logic [31:0]              r_rate, n_rate;
    logic [15:0]              r_depth, n_depth;
    logic [7:0]               r_low, n_low;
    logic [CI_W-1:0]          r_idx, n_idx;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [FRAME_W-1:0]       r_left, n_left;
    logic                     n_jv;
    t_job                     n_job;

    always_comb begin
        t_phase                  ph;
        logic [31:0]             bc, tag, sz, bc1;
        logic [15:0]             ch;
        logic [31:0]             rt;
        logic [15:0]             dp;
        logic [CI_W-1:0]         idx;
        logic signed [SUM_W-1:0] sm;
        logic [FRAME_W-1:0]      lf, half, after;
        logic [SUM_W-1:0]        mag;
        logic [15:0]             smp;

        ph = r_phase; bc = r_bc; tag = r_tag; sz = r_size; ch = r_chan;
        rt = r_rate; dp = r_depth; idx = r_idx; sm = r_sum; lf = r_left;
        n_low = r_low;
        if (i_file_start) begin
            ph = PH_RIFF; bc = '0; tag = '0; sz = '0; ch = '0; rt = '0; dp = '0;
            idx = '0; sm = '0; lf = '0; n_low = '0;
        end
        n_jv  = 1'b0;
        n_job = '{kind: KIND_ERROR, neg: 1'b0, dividend: '0, rate: '0, channels: '0};
        bc1   = bc + 32'd1;
        half  = sz[31:1];
        after = '0;
        mag   = '0;
        smp   = '0;

        case (ph)
            PH_RIFF, PH_WAVE: begin
                tag = {tag[23:0], i_data_byte};
                bc  = bc1;
                if (bc >= 32'd4) begin
                    bc = '0;
                    if (ph == PH_RIFF) begin
                        if (tag != TAG_RIFF) begin
                            n_jv = 1'b1; ph = PH_IDLE;
                        end else begin
                            ph = PH_RIFFSIZE;
                        end
                    end else begin
                        if (tag != TAG_WAVE) begin
                            n_jv = 1'b1; ph = PH_IDLE;
                        end else begin
                            ph = PH_HDR;
                        end
                    end
                    tag = '0;
                end
            end
            PH_RIFFSIZE: begin
                bc = bc1;
                if (bc >= 32'd4) begin
                    bc = '0; ph = PH_WAVE;
                end
            end
            PH_HDR: begin
                if (bc == '0) sz = '0;
                if (bc < 32'd4) begin
                    tag = {tag[23:0], i_data_byte};
                end else begin
                    case (bc[1:0])
                        2'd0:    sz[7:0]   = sz[7:0]   | i_data_byte;
                        2'd1:    sz[15:8]  = sz[15:8]  | i_data_byte;
                        2'd2:    sz[23:16] = sz[23:16] | i_data_byte;
                        default: sz[31:24] = sz[31:24] | i_data_byte;
                    endcase
                end
                bc = bc1;
                half = sz[31:1];
                if (bc >= 32'd8) begin
                    bc = '0;
                    if (tag == TAG_FMT) begin
                        if (sz < FMT_LEN) begin
                            n_jv = 1'b1; ph = PH_IDLE;
                        end else begin
                            ph = PH_FMT;
                        end
                    end else if (tag == TAG_DATA) begin
                        n_jv = 1'b1;
                        if (dp != PCM_DEPTH || ch == '0 || ch > 16'(MAX_CHANNELS)) begin
                            ph = PH_IDLE;
                        end else begin
                            n_job.kind     = KIND_INFO;
                            n_job.dividend = half;
                            n_job.rate     = rt;
                            n_job.channels = ch;
                            lf  = half;
                            idx = '0;
                            sm  = '0;
                            ph  = (half < FRAME_W'(ch)) ? PH_IDLE : PH_DATA;
                        end
                    end else begin
                        bc = sz;
                        if (bc != '0)    ph = PH_SKIP;
                        else if (sz[0])  ph = PH_PAD;
                        else             ph = PH_HDR;
                    end
                end
            end
            PH_FMT: begin
                case (bc[3:0])
                    4'd2:    ch[7:0]   = i_data_byte;
                    4'd3:    ch[15:8]  = i_data_byte;
                    4'd4:    rt[7:0]   = i_data_byte;
                    4'd5:    rt[15:8]  = i_data_byte;
                    4'd6:    rt[23:16] = i_data_byte;
                    4'd7:    rt[31:24] = i_data_byte;
                    4'd14:   dp[7:0]   = i_data_byte;
                    4'd15:   dp[15:8]  = i_data_byte;
                    default: ;
                endcase
                bc = bc1;
                if (bc >= FMT_LEN) begin
                    bc = sz - FMT_LEN;
                    if (bc != '0)    ph = PH_SKIP;
                    else if (sz[0])  ph = PH_PAD;
                    else             ph = PH_HDR;
                end
            end
            PH_SKIP: begin
                bc = bc - 32'd1;
                if (bc == '0) begin
                    if (sz[0]) ph = PH_PAD;
                    else       ph = PH_HDR;
                end
            end
            PH_PAD: begin
                ph = PH_HDR; bc = '0;
            end
            PH_DATA: begin
                if (!bc[0]) begin
                    n_low = i_data_byte;
                    bc    = 32'd1;
                end else begin
                    bc  = '0;
                    smp = {i_data_byte, n_low};
                    sm  = sm + SUM_W'($signed(smp));
                    idx = idx + CI_W'(1);
                    if (16'(idx) >= ch) begin
                        n_jv = 1'b1;
                        mag  = sm[SUM_W-1] ? SUM_W'(-sm) : SUM_W'(sm);
                        n_job.kind     = KIND_SAMPLE;
                        n_job.neg      = sm[SUM_W-1];
                        n_job.dividend = FRAME_W'(mag);
                        n_job.channels = ch;
                        sm    = '0;
                        idx   = '0;
                        after = lf - FRAME_W'(ch);
                        lf    = after;
                        if (after < FRAME_W'(ch)) ph = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase

        n_phase = ph; n_bc = bc; n_tag = tag; n_size = sz; n_chan = ch;
        n_rate = rt; n_depth = dp; n_idx = idx; n_sum = sm; n_left = lf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_bc <= '0; r_tag <= '0; r_size <= '0; r_chan <= '0; r_rate <= '0;
            r_depth <= '0; r_low <= '0; r_idx <= '0; r_sum <= '0; r_left <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_bc <= n_bc; r_tag <= n_tag; r_size <= n_size; r_chan <= n_chan;
            r_rate <= n_rate; r_depth <= n_depth; r_low <= n_low; r_idx <= n_idx;
            r_sum <= n_sum; r_left <= n_left;
        end
    end

    assign o_job_valid = i_take & n_jv;
    assign o_job       = n_job;

endmodule

// ===== rtl/core/wspd_fifo.sv =====
// Small register queue of jobs between parser and divider.
module wspd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wspd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output wspd_pkg::t_job o_job
);
    import wspd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop)  r_rd <= bump(r_rd);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// ===== rtl/core/wspd_back.sv =====
// Bit-serial divider and output register: frame count and downmix quotients.
module wspd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  wspd_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_sample,
    output logic [31:0]    o_sample_rate,
    output logic [15:0]    o_channel_count,
    output logic [30:0]    o_frame_count
);
    import wspd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic [FRAME_W-1:0]  r_quo;
    logic [DIV_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ovalid;
    logic [1:0]          r_kind;
    logic [15:0]         r_sample, r_chan;
    logic [31:0]         r_rate;
    logic [30:0]         r_frames;

    logic [DIV_W:0]      w_trial;
    logic                w_ge;
    logic                w_out_free;
    logic [15:0]         w_q16;

    assign w_trial    = {r_rem, r_quo[FRAME_W-1]};
    assign w_ge       = w_trial >= (DIV_W+1)'(r_job.channels[DIV_W-1:0] == '0 ?
                        (DIV_W+1)'(16) : (DIV_W+1)'(r_job.channels[DIV_W-1:0]));
    assign w_out_free = !r_ovalid || i_pop;
    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid;
    assign w_q16      = r_job.neg ? 16'(-r_quo[15:0]) : r_quo[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (i_pop)                      r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_quo <= i_job.dividend;
                        r_rem <= '0;
                        r_cnt <= CNT_W'(FRAME_W - 1);
                        r_state <= (i_job.kind == KIND_ERROR) ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_quo <= {r_quo[FRAME_W-2:0], w_ge};
                    r_rem <= w_ge ? DIV_W'(w_trial - (DIV_W+1)'(r_job.channels[DIV_W:0]))
                                  : w_trial[DIV_W-1:0];
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_kind   <= r_job.kind;
                        r_sample <= (r_job.kind == KIND_SAMPLE) ? w_q16 : '0;
                        r_rate   <= (r_job.kind == KIND_INFO) ? r_job.rate : '0;
                        r_chan   <= (r_job.kind == KIND_INFO) ? r_job.channels : '0;
                        r_frames <= (r_job.kind == KIND_INFO) ? r_quo : '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_empty         = !r_ovalid;
    assign o_kind          = r_kind;
    assign o_sample        = r_sample;
    assign o_sample_rate   = r_rate;
    assign o_channel_count = r_chan;
    assign o_frame_count   = r_frames;

endmodule

// ===== rtl/core/wav_stream_parse_downmix.sv =====
// Top level: WAV byte parser with 16-bit PCM mono downmix.
// Input: one byte per cycle while the job queue has room (full follows the queue).
// Each sample or info result takes one divide of 31 single-bit steps in the back
// unit, which takes no new job until that result is registered; error results skip
// the divide. Bytes that make no result pass at one per cycle.
// Synchronous active-low reset clears parser phase, queue pointers and output valid.
module wav_stream_parse_downmix #(
    parameter int MAX_CHANNELS = 8,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic signed [15:0] o_sample,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_channel_count,
    output logic [30:0] o_frame_count
);
    import wspd_pkg::*;

    // Front side: a byte transfer happens when push is high and the queue is not full.
    logic  w_take;
    logic  w_job_push;
    t_job  w_job_in;
    // Queue to back side.
    logic  w_q_empty;
    logic  w_q_pop;
    t_job  w_job_out;
    logic [15:0] w_sample;

    assign w_take = push && !full;

    wspd_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_job_valid  (w_job_push),
        .o_job        (w_job_in)
    );

    // Decouples the parser from the serial divider; at most one job per byte.
    wspd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_job   (w_job_out)
    );

    // Back side: divides frame sums and halved data-chunk sizes by the channel count.
    wspd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (!w_q_empty),
        .i_job           (w_job_out),
        .o_job_pop       (w_q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_sample        (w_sample),
        .o_sample_rate   (o_sample_rate),
        .o_channel_count (o_channel_count),
        .o_frame_count   (o_frame_count)
    );

    assign o_sample = $signed(w_sample);

    // A job is only produced on a byte transfer, which requires queue room.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_job_push && full)) else $error("job pushed into full queue");

    a_info_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_INFO) |-> (o_channel_count != 16'd0 &&
        o_channel_count <= 16'(MAX_CHANNELS))) else $error("bad info channel count");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_ERROR) |-> (o_sample == 16'sd0 &&
        o_sample_rate == 32'd0 && o_channel_count == 16'd0 && o_frame_count == 31'd0))
        else $error("error result carries data");

    a_queue_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_pop && w_q_empty)) else $error("pop from empty queue");

endmodule
